// ===== rtl/core/sobth_pkg.sv =====
package sobth_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int THR_W      = 11;
	localparam int MAG_W      = 11;
	localparam int SUM_W      = 22;
	localparam int GRAD_W     = 11;
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DAT_W  = 13;
	localparam int OUT_DAT_W  = 40;
	localparam int ROOT_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_CALC, S_SQX, S_SQY, S_SQT, S_ROOT, S_DONE
	} state_t;

	typedef struct packed {
		logic [FW_W-1:0]  frame_width;
		logic [FH_W-1:0]  frame_height;
		logic [THR_W-1:0] edge_threshold;
		logic [COL_W-1:0] region_left;
		logic [ROW_W-1:0] region_top;
		logic [COL_W-1:0] region_right;
		logic [ROW_W-1:0] region_bottom;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic calc;
		logic sq_x;
		logic sq_y;
		logic sq_t;
		logic root_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic root_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/sobel_edge_threshold.sv =====
// Channel   Direction  Contents
// s_axis    in         tdata: pixel; tuser: start_of_frame
// m_axis    out        tdata: column, row, magnitude; tuser: edge_res; tlast: frame_done
// cfg       in         cfg_index selects the register, cfg_data carries its value
//
// A border pixel passes only the idle, read and calc states; an interior pixel then
// passes SQX, SQY, SQT, the 11 steps of the bit-serial square root and S_DONE.
// Reset clears counters, window, config and tvalid; the line stores start undefined.
// A finished result waits in the output register while the next pixel is taken.
// Configuration writes are taken every cycle.
module sobel_edge_threshold (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // pixel
	input  logic                                s_tuser,   // start_of_frame
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sobth_pkg::OUT_DAT_W-1:0]     m_tdata,   // column, row, magnitude
	output logic                                m_tuser,   // edge_res
	output logic                                m_tlast,   // frame_done
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sobth_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sobth_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import sobth_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= FW_W'(640);
			cfg_q.frame_height <= FH_W'(480);
			cfg_q.edge_threshold <= THR_W'(64);
			cfg_q.region_left <= '0;
			cfg_q.region_top <= '0;
			cfg_q.region_right <= '1;
			cfg_q.region_bottom <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FH_W-1:0];
				REG_EDGE_THRESH: cfg_q.edge_threshold <= cfg_data[THR_W-1:0];
				REG_REGION_LEFT: cfg_q.region_left <= cfg_data[COL_W-1:0];
				REG_REGION_TOP: cfg_q.region_top <= cfg_data[ROW_W-1:0];
				REG_REGION_RIGHT: cfg_q.region_right <= cfg_data[COL_W-1:0];
				REG_REGION_BOTTOM: cfg_q.region_bottom <= cfg_data[ROW_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	sobth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sobth_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.st             (st),
		.pixel          (s_tdata),
		.start_of_frame (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast)
	);

endmodule

// ===== rtl/core/sobth_ctrl.sv =====
module sobth_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  sobth_pkg::status_t st,
	output sobth_pkg::cmd_t  cmd
);
	import sobth_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_READ;
			end
			S_READ: state_nxt = S_CALC;
			S_CALC: begin
				state_nxt = st.interior ? S_SQX : S_IDLE;
			end
			S_SQX: state_nxt = S_SQY;
			S_SQY: state_nxt = S_SQT;
			S_SQT: state_nxt = S_ROOT;
			S_ROOT: begin
				if (st.root_last) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.capture = s_tvalid;
			end
			S_READ: cmd.rd = 1'b1;
			S_CALC: cmd.calc = 1'b1;
			S_SQX: cmd.sq_x = 1'b1;
			S_SQY: cmd.sq_y = 1'b1;
			S_SQT: cmd.sq_t = 1'b1;
			S_ROOT: cmd.root_step = 1'b1;
			S_DONE: cmd.load_out = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/sobth_dp.sv =====
module sobth_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sobth_pkg::cfg_t                  cfg,
	input  sobth_pkg::cmd_t                  cmd,
	output sobth_pkg::status_t               st,
	input  logic [sobth_pkg::PIX_W-1:0]      pixel,
	input  logic                             start_of_frame,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sobth_pkg::OUT_DAT_W-1:0]  m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import sobth_pkg::*;

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [PIX_W-1:0] win_q [6];
	logic [COL_W-1:0] col_q, cur_c_q;
	logic [ROW_W-1:0] row_q, cur_r_q;
	logic [PIX_W-1:0] px_q, up_q, md_q;

	logic signed [GRAD_W-1:0] gx_q, gy_q;
	logic [SUM_W-1:0] sqx_q, sum_q, thrsq_q, rem_q;
	logic [SUM_W-1:0] res_q;
	logic [ROOT_W-1:0] cnt_q;
	logic [COL_W-1:0] oc_q;
	logic [ROW_W-1:0] orow_q;
	logic inside_q, fdone_q;

	logic m_tvalid_q, m_edge_q, m_last_q;
	logic [COL_W-1:0] m_col_q;
	logic [ROW_W-1:0] m_row_q;
	logic [MAG_W-1:0] m_mag_q;

	logic [FW_W-1:0] w;
	logic [FH_W-1:0] h;
	logic [FW_W-1:0] c_ext, c_inc;
	logic [FH_W-1:0] r_ext, r_inc;
	logic [COL_W-1:0] oc;
	logic [ROW_W-1:0] orow;
	logic [GRAD_W:0] sum_pos_x, sum_neg_x, sum_pos_y, sum_neg_y;
	logic signed [GRAD_W:0] gx_w, gy_w;
	logic [SUM_W-1:0] bit_v, trial;

	always_comb begin
		if (cfg.frame_width < FW_W'(3)) w = FW_W'(3);
		else if (cfg.frame_width > FW_W'(MAX_WIDTH)) w = FW_W'(MAX_WIDTH);
		else w = cfg.frame_width;
		if (cfg.frame_height < FH_W'(3)) h = FH_W'(3);
		else if (cfg.frame_height > FH_W'(MAX_HEIGHT)) h = FH_W'(MAX_HEIGHT);
		else h = cfg.frame_height;
	end

	assign c_ext = FW_W'(cur_c_q);
	assign r_ext = FH_W'(cur_r_q);
	assign c_inc = c_ext + FW_W'(1);
	assign r_inc = r_ext + FH_W'(1);
	assign oc = cur_c_q - COL_W'(1);
	assign orow = cur_r_q - ROW_W'(1);

	assign st.interior = (cur_c_q >= COL_W'(2)) && (cur_r_q >= ROW_W'(2))
		&& (c_ext < w) && (r_ext < h);
	assign st.root_last = (cnt_q == '0);
	assign st.out_free = !m_tvalid_q || m_tready;

	assign sum_pos_x = (GRAD_W+1)'(up_q) + {(GRAD_W-PIX_W)'(0), md_q, 1'b0}
		+ (GRAD_W+1)'(px_q);
	assign sum_neg_x = (GRAD_W+1)'(win_q[0]) + {(GRAD_W-PIX_W)'(0), win_q[2], 1'b0}
		+ (GRAD_W+1)'(win_q[4]);
	assign sum_pos_y = (GRAD_W+1)'(win_q[4]) + {(GRAD_W-PIX_W)'(0), win_q[5], 1'b0}
		+ (GRAD_W+1)'(px_q);
	assign sum_neg_y = (GRAD_W+1)'(win_q[0]) + {(GRAD_W-PIX_W)'(0), win_q[1], 1'b0}
		+ (GRAD_W+1)'(up_q);
	assign gx_w = $signed(sum_pos_x) - $signed(sum_neg_x);
	assign gy_w = $signed(sum_pos_y) - $signed(sum_neg_y);

	assign bit_v = SUM_W'(1) << {cnt_q, 1'b0};
	assign trial = res_q + bit_v;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			up_q <= upper_mem[cur_c_q];
			md_q <= middle_mem[cur_c_q];
		end
		if (cmd.calc) begin
			upper_mem[cur_c_q] <= md_q;
			middle_mem[cur_c_q] <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
			col_q <= '0;
			row_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.calc) begin
				win_q[0] <= win_q[1];
				win_q[1] <= up_q;
				win_q[2] <= win_q[3];
				win_q[3] <= md_q;
				win_q[4] <= win_q[5];
				win_q[5] <= px_q;
				if (c_inc >= w) begin
					col_q <= '0;
					row_q <= (r_inc >= h) ? '0 : ROW_W'(r_inc);
				end else begin
					col_q <= COL_W'(c_inc);
					row_q <= (r_ext >= h) ? '0 : cur_r_q;
				end
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= pixel;
			cur_c_q <= start_of_frame ? '0 : col_q;
			cur_r_q <= start_of_frame ? '0 : row_q;
		end
		if (cmd.calc) begin
			gx_q <= GRAD_W'(gx_w);
			gy_q <= GRAD_W'(gy_w);
			oc_q <= oc;
			orow_q <= orow;
			inside_q <= (oc >= cfg.region_left) && (oc <= cfg.region_right)
				&& (orow >= cfg.region_top) && (orow <= cfg.region_bottom);
			fdone_q <= (c_inc == w) && (r_inc == h);
		end
		if (cmd.sq_x) begin
			sqx_q <= $unsigned(SUM_W'(gx_q) * SUM_W'(gx_q));
		end
		if (cmd.sq_y) begin
			sum_q <= sqx_q + $unsigned(SUM_W'(gy_q) * SUM_W'(gy_q));
		end
		if (cmd.sq_t) begin
			thrsq_q <= SUM_W'(cfg.edge_threshold) * SUM_W'(cfg.edge_threshold);
			rem_q <= sum_q;
			res_q <= '0;
			cnt_q <= ROOT_W'(MAG_W - 1);
		end
		if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_v;
			end else begin
				res_q <= res_q >> 1;
			end
			cnt_q <= cnt_q - ROOT_W'(1);
		end
		if (cmd.load_out) begin
			m_col_q <= oc_q;
			m_row_q <= orow_q;
			m_mag_q <= MAG_W'(res_q);
			m_edge_q <= inside_q && (sum_q >= thrsq_q);
			m_last_q <= fdone_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {(OUT_DAT_W-COL_W-ROW_W-MAG_W)'(0), m_mag_q, m_row_q, m_col_q};
	assign m_tuser = m_edge_q;
	assign m_tlast = m_last_q;

endmodule

// ===== bench/sobel_edge_checker.sv =====
module sobel_edge_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [sobth_pkg::OUT_DAT_W-1:0] m_tdata,
	input  logic                            m_tuser,
	input  logic                            m_tlast,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sobth_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sobth_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                              fails,
	output int                              pending
);
	import sobth_pkg::*;

	typedef struct packed {
		logic [10:0] col;
		logic [11:0] row;
		logic [10:0] mag;
		logic        is_edge;
		logic        done;
	} gradient_t;

	gradient_t expected_grads[$];

	logic [7:0]  upper_line [MAX_WIDTH];
	logic [7:0]  middle_line [MAX_WIDTH];
	logic [7:0]  win [6];
	int unsigned col_pos, row_pos;
	int unsigned width_reg, height_reg, thresh_reg;
	int unsigned left_reg, top_reg, right_reg, bottom_reg;

	function automatic int unsigned root_floor(int unsigned s);
		int unsigned r;
		r = 0;
		for (int b = 10; b >= 0; b--) begin
			int unsigned t;
			t = r | (1 << b);
			if (t * t <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic predict_pixel(input logic [7:0] px, input logic sof);
		int unsigned w, h, c, r, idx, s, oc, orow;
		int t0, t1, t2, m0, m2, b0, b1, b2, gx, gy;
		logic [7:0] up, md;
		gradient_t g;
		w = clamp_to(width_reg, 3, MAX_WIDTH);
		h = clamp_to(height_reg, 3, MAX_HEIGHT);
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		idx = c % MAX_WIDTH;
		up = upper_line[idx];
		md = middle_line[idx];
		upper_line[idx] = md;
		middle_line[idx] = px;
		t0 = win[0]; t1 = win[1]; t2 = up;
		m0 = win[2]; m2 = md;
		b0 = win[4]; b1 = win[5]; b2 = px;
		if (c >= 2 && r >= 2 && c < w && r < h) begin
			gx = -t0 + t2 - 2 * m0 + 2 * m2 - b0 + b2;
			gy = -t0 - 2 * t1 - t2 + b0 + 2 * b1 + b2;
			s = gx * gx + gy * gy;
			oc = c - 1;
			orow = r - 1;
			g.col = oc[10:0];
			g.row = orow[11:0];
			g.mag = 11'(root_floor(s));
			g.is_edge = oc >= left_reg && oc <= right_reg && orow >= top_reg &&
				orow <= bottom_reg && s >= thresh_reg * thresh_reg;
			g.done = (c == w - 1) && (r == h - 1);
			expected_grads = {expected_grads, g};
		end
		win[0] = t1; win[1] = up;
		win[2] = win[3]; win[3] = md;
		win[4] = b1; win[5] = px;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			if (r >= h)
				row_pos = 0;
		end
	endtask

	task automatic check_word();
		gradient_t g, got;
		got.col = m_tdata[10:0];
		got.row = m_tdata[22:11];
		got.mag = m_tdata[33:23];
		got.is_edge = m_tuser;
		got.done = m_tlast;
		if (expected_grads.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected word: col %0d row %0d mag %0d edge %0b done %0b",
					got.col, got.row, got.mag, got.is_edge, got.done);
		end else begin
			g = expected_grads.pop_front();
			if (g !== got || m_tdata[39:34] !== '0) begin
				fails++;
				if (fails <= 10) begin
					$display("mismatch: expected col %0d row %0d mag %0d edge %0b done %0b,",
						g.col, g.row, g.mag, g.is_edge, g.done);
					$display("  got col %0d row %0d mag %0d edge %0b done %0b",
						got.col, got.row, got.mag, got.is_edge, got.done);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_grads.delete();
			fails = 0;
			for (int i = 0; i < 6; i++)
				win[i] = '0;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			width_reg = 640;
			height_reg = 480;
			thresh_reg = 64;
			left_reg = 0;
			top_reg = 0;
			right_reg = 2047;
			bottom_reg = 4095;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_FRAME_WIDTH: width_reg = cfg_data[11:0];
				REG_FRAME_HEIGHT: height_reg = cfg_data[12:0];
				REG_EDGE_THRESH: thresh_reg = cfg_data[10:0];
				REG_REGION_LEFT: left_reg = cfg_data[10:0];
				REG_REGION_TOP: top_reg = cfg_data[11:0];
				REG_REGION_RIGHT: right_reg = cfg_data[10:0];
				REG_REGION_BOTTOM: bottom_reg = cfg_data[11:0];
				default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_word();
			if (s_tvalid && s_tready)
				predict_pixel(s_tdata, s_tuser);
		end
		pending = expected_grads.size();
	end
endmodule

// ===== bench/tb_sobel_edge_threshold.sv =====
module tb_sobel_edge_threshold;
	import sobth_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_DAT_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	int                   fails;
	int                   pending;
	int                   sent;
	bit                   no_gaps;
	bit                   hold_output;
	bit                   hold_done;

	always #6 clk = ~clk;

	sobel_edge_threshold dut (.*);

	sobel_edge_checker checker_i (.*);

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return 0;
		if (k < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (500) @(posedge clk);
				hold_output = 1'b0;
				hold_done = 1'b1;
			end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_pixel(input logic [7:0] px, input logic sof);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tuser <= sof;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(input int w, input int h, input int thr, input int l,
			input int t, input int r, input int b);
		logic [CFG_IDX_W-1:0] idx [7];
		int val [7];
		idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_EDGE_THRESH, REG_REGION_LEFT,
			REG_REGION_TOP, REG_REGION_RIGHT, REG_REGION_BOTTOM};
		val = '{w, h, thr, l, t, r, b};
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= CFG_DAT_W'(val[i]);
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One frame or part of one; style 0 is random, 1 a diagonal step, 2 a slow ramp.
	task automatic send_frame(input int w, input int h, input int count, input int style,
			input bit sof);
		logic [7:0] px;
		for (int i = 0; i < count; i++) begin
			case (style)
			0: px = 8'($urandom_range(0, 255));
			1: px = ((i % w) + (i / w) >= 2) ? 8'hFF : 8'h00;
			default: px = 8'(i * 7 + $urandom_range(0, 3));
			endcase
			send_pixel(px, sof && i == 0);
		end
	endtask

	initial begin
		int w, h, ew, eh, frames, k;
		sent = 0;
		no_gaps = 1'b0;
		hold_output = 1'b0;
		hold_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(3, 3, 0, 0, 0, 2047, 4095);
		send_frame(3, 3, 9, 1, 1'b1);
		send_frame(3, 3, 9, 0, 1'b0);
		wait_idle();
		write_regs(0, 1, 2047, 2047, 4095, 0, 0);
		send_frame(3, 3, 9, 1, 1'b1);
		send_frame(3, 3, 5, 0, 1'b1);
		send_frame(3, 3, 9, 0, 1'b1);
		wait_idle();

		// Shrink the height while the counters stand below the new last row.
		write_regs(5, 8, 10, 1, 1, 3, 5);
		send_frame(5, 8, 32, 0, 1'b1);
		wait_idle();
		write_regs(5, 4, 10, 1, 1, 3, 5);
		send_frame(5, 4, 30, 0, 1'b0);
		wait_idle();

		while (sent < 1600) begin
			k = $urandom_range(0, 9);
			w = (k == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			k = $urandom_range(0, 9);
			h = (k == 0) ? $urandom_range(0, 2) : (k == 1 ? 8191 : $urandom_range(3, 8));
			ew = w < 3 ? 3 : w;
			eh = h < 3 ? 3 : (h > MAX_HEIGHT ? 8 : h);
			k = $urandom_range(0, 3);
			write_regs(w, h,
				k == 0 ? 0 : (k == 1 ? 2047 : $urandom_range(1, 600)),
				$urandom_range(0, 2047) & ($urandom_range(0, 1) ? 15 : 2047),
				$urandom_range(0, 4095) & ($urandom_range(0, 1) ? 7 : 4095),
				$urandom_range(0, 2047), $urandom_range(0, 4095));
			no_gaps = ($urandom_range(0, 4) == 0);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				if (!hold_done && sent > 800)
					hold_output = 1'b1;
				k = $urandom_range(0, 9);
				send_frame(ew, eh, k == 0 ? $urandom_range(1, ew * eh) : ew * eh,
					$urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2),
					f == 0 || $urandom_range(0, 9) < 7);
			end
			no_gaps = 1'b0;
			wait_idle();
		end

		write_regs(4095, 3, 1443, 2047, 0, 2047, 4095);
		send_frame(2048, 3, 120, 0, 1'b1);
		wait_idle();
		write_regs(3, 4096, 1, 0, 4094, 2047, 4095);
		send_frame(3, 4096, 30, 0, 1'b1);
		wait_idle();

		if (fails == 0)
			$display("** sobel_edge_threshold: PASSED **");
		else
			$display("** sobel_edge_threshold: FAILED **");
		$finish;
	end

	initial begin
		#40000000;
		$display("** sobel_edge_threshold: FAILED **");
		$finish;
	end
endmodule
